>>> hw/rtl/lbcd_pkg.sv
// Shared word types and action codes for the LRU block cache directory.
package lbcd_pkg;

  localparam int BLOCK_W = 32;
  localparam int SLOT_FIELD_W = 4;
  localparam int COUNT_W = 32;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [BLOCK_W-1:0] block_id;
  } req_word_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    evicted_valid;
    logic [BLOCK_W-1:0]      evicted_block;
    logic                    sequential;
    logic [COUNT_W-1:0]      request_total;
    logic [COUNT_W-1:0]      sequential_total;
    logic [COUNT_W-1:0]      random_total;
  } rsp_word_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] slot;
    logic                    evicted_valid;
    logic [BLOCK_W-1:0]      evicted_block;
  } dir_resp_t;

  typedef struct packed {
    logic               sequential;
    logic [COUNT_W-1:0] request_total;
    logic [COUNT_W-1:0] sequential_total;
    logic [COUNT_W-1:0] random_total;
  } stats_resp_t;

endpackage

>>> hw/rtl/lbcd_dir.sv
// Slot directory: tags, valid bits, LRU ranks, parallel match and replacement choice.
module lbcd_dir #(
  parameter int CACHE_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [1:0]                        op,
  input  logic [lbcd_pkg::BLOCK_W-1:0]      id,
  output lbcd_pkg::dir_resp_t               resp
);

  localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] RANK_MRU = SLOT_W'(CACHE_SLOTS - 1);

  logic [CACHE_SLOTS-1:0]          valid;
  logic [lbcd_pkg::BLOCK_W-1:0]    tag [CACHE_SLOTS];
  logic [SLOT_W-1:0]               rank [CACHE_SLOTS];
  logic [SLOT_W-1:0]               rank_next [CACHE_SLOTS];

  logic [CACHE_SLOTS-1:0] match;
  logic [CACHE_SLOTS-1:0] lru_vec;
  logic [CACHE_SLOTS-1:0] mru_vec;
  logic                   hit_any;
  logic                   free_any;
  logic [SLOT_W-1:0]      hit_idx;
  logic [SLOT_W-1:0]      free_idx;
  logic [SLOT_W-1:0]      lru_idx;
  logic [SLOT_W-1:0]      tgt;
  logic [SLOT_W-1:0]      tgt_rank;
  logic                   touch_en;
  logic                   alloc;
  logic                   evict;
  logic                   flush;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      match[i]   = valid[i] && (tag[i] == id);
      lru_vec[i] = (rank[i] == '0);
      mru_vec[i] = (rank[i] == RANK_MRU);
      if (match[i]) begin
        hit_idx = SLOT_W'(i);
      end
      if (!valid[i]) begin
        free_idx = SLOT_W'(i);
      end
      if (lru_vec[i]) begin
        lru_idx = SLOT_W'(i);
      end
    end
    hit_any  = |match;
    free_any = ~&valid;

    tgt      = hit_idx;
    touch_en = 1'b0;
    alloc    = 1'b0;
    evict    = 1'b0;
    flush    = 1'b0;
    case (op)
      lbcd_pkg::ACT_LOOKUP: begin
        touch_en = hit_any;
      end
      lbcd_pkg::ACT_FILL: begin
        touch_en = 1'b1;
        alloc    = !hit_any;
        evict    = !hit_any && !free_any;
        if (!hit_any) begin
          tgt = free_any ? free_idx : lru_idx;
        end
      end
      lbcd_pkg::ACT_FLUSH: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase

    // Promote the target to most recent; everything above it drops one rank.
    tgt_rank = rank[tgt];
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (touch_en && (tgt == SLOT_W'(i))) begin
        rank_next[i] = RANK_MRU;
      end else if (touch_en && (rank[i] > tgt_rank)) begin
        rank_next[i] = rank[i] - SLOT_W'(1);
      end else begin
        rank_next[i] = rank[i];
      end
    end

    resp.hit           = (op == lbcd_pkg::ACT_LOOKUP || op == lbcd_pkg::ACT_FILL) && hit_any;
    resp.slot          = touch_en ? lbcd_pkg::SLOT_FIELD_W'(tgt) : '0;
    resp.evicted_valid = evict;
    resp.evicted_block = evict ? tag[tgt] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        rank[i] <= SLOT_W'(i);
      end
    end else if (en) begin
      if (flush) begin
        valid <= '0;
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          rank[i] <= SLOT_W'(i);
        end
      end else begin
        if (alloc) begin
          valid[tgt] <= 1'b1;
        end
        for (int i = 0; i < CACHE_SLOTS; i++) begin
          rank[i] <= rank_next[i];
        end
      end
    end
  end

  // Tags carry no reset: an invalid slot's tag is never observed.
  always_ff @(posedge clk) begin
    if (en && alloc) begin
      tag[tgt] <= id;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_mru: assert property (@(posedge clk) disable iff (rst) $onehot(mru_vec))
    else $error("lbcd_dir: ranks lost the single most recent slot");
  a_one_lru: assert property (@(posedge clk) disable iff (rst) $onehot(lru_vec))
    else $error("lbcd_dir: ranks lost the single least recent slot");
`endif

endmodule

>>> hw/rtl/lbcd_stats.sv
// Fill locality check and saturating request counters.
module lbcd_stats (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [1:0]                   op,
  input  logic [lbcd_pkg::BLOCK_W-1:0] id,
  output lbcd_pkg::stats_resp_t        resp
);

  localparam logic [lbcd_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  function automatic logic [lbcd_pkg::COUNT_W-1:0] sat_inc(
    input logic [lbcd_pkg::COUNT_W-1:0] v
  );
    return (v == COUNT_MAX) ? v : v + lbcd_pkg::COUNT_W'(1);
  endfunction

  logic [lbcd_pkg::BLOCK_W-1:0] prev_fill;
  logic                         prev_valid;
  logic [lbcd_pkg::COUNT_W-1:0] lookups;
  logic [lbcd_pkg::COUNT_W-1:0] seqs;
  logic [lbcd_pkg::COUNT_W-1:0] rnds;
  logic [lbcd_pkg::COUNT_W-1:0] lookups_next;
  logic [lbcd_pkg::COUNT_W-1:0] seqs_next;
  logic [lbcd_pkg::COUNT_W-1:0] rnds_next;
  logic [lbcd_pkg::BLOCK_W:0]   id_up;
  logic [lbcd_pkg::BLOCK_W:0]   prev_up;
  logic                         near;
  logic                         is_fill;

  always_comb begin
    // Neighbor test without wrap: compare in one extra bit.
    id_up   = {1'b0, id} + (lbcd_pkg::BLOCK_W + 1)'(1);
    prev_up = {1'b0, prev_fill} + (lbcd_pkg::BLOCK_W + 1)'(1);
    near    = prev_valid && ((id == prev_fill) || (id_up == {1'b0, prev_fill}) ||
                             (prev_up == {1'b0, id}));
    is_fill = (op == lbcd_pkg::ACT_FILL);

    lookups_next = (op == lbcd_pkg::ACT_LOOKUP) ? sat_inc(lookups) : lookups;
    seqs_next    = (is_fill && near) ? sat_inc(seqs) : seqs;
    rnds_next    = (is_fill && !near) ? sat_inc(rnds) : rnds;

    resp.sequential       = is_fill && near;
    resp.request_total    = lookups_next;
    resp.sequential_total = seqs_next;
    resp.random_total     = rnds_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_fill  <= '0;
      prev_valid <= 1'b0;
      lookups    <= '0;
      seqs       <= '0;
      rnds       <= '0;
    end else if (en) begin
      lookups <= lookups_next;
      seqs    <= seqs_next;
      rnds    <= rnds_next;
      if (is_fill) begin
        prev_fill  <= id;
        prev_valid <= 1'b1;
      end else if (op == lbcd_pkg::ACT_FLUSH) begin
        prev_fill  <= '0;
        prev_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/lru_block_cache_directory.sv
// Top level of the LRU block cache directory: request register, directory, result register.
//
// Usage:
//   A request word (action, block_id) enters on req when req_valid is high and
//   req_stall is low. Actions: lookup, fill, flush; the unused code changes nothing.
//   Each request yields exactly one result word on rsp, in order, offered with
//   rsp_valid and taken when rsp_stall is low.
//   An accepted request waits in the request register until the result register is
//   free or draining. Throughput: one word per cycle while rsp_stall is low; all tag
//   compares, the LRU rank update and the counter increments run combinationally
//   between the request register and the result register.
//   The slot field addresses an external data memory; no block data moves here.
//   Stall: while rsp_stall holds a result, the request register still takes one
//   more word; req_stall rises only when both registers are full.
//   Reset (rst, synchronous): every slot empties, ranks return to slot order,
//   the previous-fill record and all three counters clear. No clearing pass.
module lru_block_cache_directory #(
  parameter int CACHE_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  lbcd_pkg::req_word_t req,
  input  logic                req_valid,
  output logic                req_stall,
  output lbcd_pkg::rsp_word_t rsp,
  output logic                rsp_valid,
  input  logic                rsp_stall
);

  lbcd_pkg::req_word_t   req_q;
  logic                  req_full;
  logic                  req_full_next;
  logic                  fire;
  logic                  accept;
  lbcd_pkg::dir_resp_t   dir_resp;
  lbcd_pkg::stats_resp_t stats_resp;

  // Advance the held request whenever the result register is free or draining.
  assign fire      = req_full && (!rsp_valid || !rsp_stall);
  assign req_stall = req_full && !fire;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    req_full_next = req_full;
    if (accept) begin
      req_full_next = 1'b1;
    end else if (fire) begin
      req_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      req_full <= req_full_next;
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: load on accept / fire, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (fire) begin
      rsp.hit              <= dir_resp.hit;
      rsp.slot             <= dir_resp.slot;
      rsp.evicted_valid    <= dir_resp.evicted_valid;
      rsp.evicted_block    <= dir_resp.evicted_block;
      rsp.sequential       <= stats_resp.sequential;
      rsp.request_total    <= stats_resp.request_total;
      rsp.sequential_total <= stats_resp.sequential_total;
      rsp.random_total     <= stats_resp.random_total;
    end
  end

  lbcd_dir #(
    .CACHE_SLOTS(CACHE_SLOTS)
  ) u_dir (
    .clk (clk),
    .rst (rst),
    .en  (fire),
    .op  (req_q.action),
    .id  (req_q.block_id),
    .resp(dir_resp)
  );

  lbcd_stats u_stats (
    .clk (clk),
    .rst (rst),
    .en  (fire),
    .op  (req_q.action),
    .id  (req_q.block_id),
    .resp(stats_resp)
  );

`ifndef NO_ASSERTIONS
  a_flush_quiet: assert property (@(posedge clk) disable iff (rst)
      fire && (req_q.action == lbcd_pkg::ACT_FLUSH) |=>
      !rsp.hit && !rsp.evicted_valid && !rsp.sequential && (rsp.slot == '0))
    else $error("lbcd: flush result carries slot information");
  a_lookup_no_evict: assert property (@(posedge clk) disable iff (rst)
      fire && (req_q.action == lbcd_pkg::ACT_LOOKUP) |=> !rsp.evicted_valid && !rsp.sequential)
    else $error("lbcd: lookup reported an eviction or a sequential fill");
  a_evict_on_miss: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp.evicted_valid |-> !rsp.hit)
    else $error("lbcd: eviction reported together with a hit");
`endif

endmodule

>>> tb/sv/lru_block_cache_directory_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LRU block cache directory: driver, monitor and directory predictor.
module lru_block_cache_directory_test;

  localparam int SLOTS          = 16;
  localparam int DIRECTED_WORDS = 25;
  localparam int RANDOM_WORDS   = 780;
  localparam int CYCLE_LIMIT    = 200000;
  // Spare edges after the last expected result, to catch stray results.
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    lbcd_pkg::req_word_t word;
    bit                  drain_first;
  } pending_word_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  lbcd_pkg::req_word_t req       = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  lbcd_pkg::rsp_word_t rsp;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;

  lru_block_cache_directory #(.CACHE_SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Directory predictor: tags, valid bits and recency ranks of every slot.
  // Rank SLOTS-1 is the most recent slot, rank zero the eviction candidate.
  // ---------------------------------------------------------------------------
  logic                         line_valid [SLOTS];
  logic [lbcd_pkg::BLOCK_W-1:0] line_tag   [SLOTS];
  logic [3:0]                   line_rank  [SLOTS];
  logic [lbcd_pkg::BLOCK_W-1:0] last_fill_id;
  logic                         last_fill_seen;
  logic [lbcd_pkg::COUNT_W-1:0] lookups_seen;
  logic [lbcd_pkg::COUNT_W-1:0] seq_fills_seen;
  logic [lbcd_pkg::COUNT_W-1:0] rand_fills_seen;

  pending_word_t       pending_q[$];
  lbcd_pkg::rsp_word_t expected_rsp_q[$];

  int  cycle_count         = 0;
  int  words_taken         = 0;
  int  word_total          = 0;
  int  fail_count          = 0;
  int  send_gap            = 0;
  int  stall_left          = 0;
  int  hold_left           = 0;
  bit  long_hold_done      = 1'b0;
  bit  req_fire            = 1'b0;
  int  backpressure_cycles = 0;
  int  hit_count           = 0;
  int  evict_count         = 0;
  int  other_words         = 0;

  function automatic logic [lbcd_pkg::COUNT_W-1:0] bump(
    input logic [lbcd_pkg::COUNT_W-1:0] c
  );
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Empty every slot, put the ranks back in slot order, forget the last fill.
  task automatic empty_directory();
    for (int i = 0; i < SLOTS; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_rank[i]  = 4'(i);
    end
    last_fill_id   = '0;
    last_fill_seen = 1'b0;
  endtask

  // Promote slot s to most recent; slots ranked above it drop by one.
  task automatic make_recent(input int s);
    logic [3:0] r;
    r = line_rank[s];
    for (int i = 0; i < SLOTS; i++)
      if (line_rank[i] > r) line_rank[i] = line_rank[i] - 1'b1;
    line_rank[s] = 4'(SLOTS - 1);
  endtask

  task automatic predict_directory(input lbcd_pkg::req_word_t w,
                                   output lbcd_pkg::rsp_word_t r);
    int                           s;
    logic [lbcd_pkg::BLOCK_W-1:0] id_gap;
    r = '0;
    // A slot only counts when it is valid and its tag still matches.
    s = SLOTS;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (line_valid[i] && line_tag[i] == w.block_id) s = i;
    case (w.action)
      lbcd_pkg::ACT_LOOKUP: begin
        lookups_seen = bump(lookups_seen);
        if (s < SLOTS) begin
          r.hit  = 1'b1;
          r.slot = 4'(s);
          make_recent(s);
        end
      end
      lbcd_pkg::ACT_FILL: begin
        if (s < SLOTS) begin
          r.hit = 1'b1;
        end else begin
          // lowest empty slot first, else the least recently used one
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!line_valid[i]) s = i;
          if (s == SLOTS) begin
            for (int i = 0; i < SLOTS; i++)
              if (line_rank[i] == '0) s = i;
            r.evicted_valid = 1'b1;
            r.evicted_block = line_tag[s];
          end
          line_valid[s] = 1'b1;
          line_tag[s]   = w.block_id;
        end
        r.slot = 4'(s);
        make_recent(s);
        // Neighbor test without wrap-around across the id range.
        if (last_fill_seen) begin
          id_gap = (w.block_id > last_fill_id) ? w.block_id - last_fill_id
                                               : last_fill_id - w.block_id;
          r.sequential = (id_gap <= 1);
        end
        if (r.sequential) seq_fills_seen = bump(seq_fills_seen);
        else              rand_fills_seen = bump(rand_fills_seen);
        last_fill_id   = w.block_id;
        last_fill_seen = 1'b1;
      end
      lbcd_pkg::ACT_FLUSH: begin
        empty_directory();
      end
      default: begin
        // unused code: state untouched
      end
    endcase
    r.request_total    = lookups_seen;
    r.sequential_total = seq_fills_seen;
    r.random_total     = rand_fills_seen;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_word(input logic [1:0] act, input logic [lbcd_pkg::BLOCK_W-1:0] id,
                            input bit drain);
    pending_word_t p;
    p.word.action   = act;
    p.word.block_id = id;
    p.drain_first   = drain;
    pending_q.push_back(p);
  endtask

  // Idle in bursts, but keep some windows and the tail of the run free of it.
  function automatic bit idle_allowed();
    return (words_taken + 120 < word_total) && ((words_taken / 90) % 4 != 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: take accepted request words into the predictor and check
  // every accepted result word against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sample_edge
    lbcd_pkg::rsp_word_t want;
    cycle_count++;
    req_fire = req_valid && !req_stall && !rst;
    if (req_valid && req_stall) backpressure_cycles++;
    if (req_fire) begin
      predict_directory(req, want);
      expected_rsp_q.push_back(want);
      void'(pending_q.pop_front());
      words_taken++;
      if (req.action != lbcd_pkg::ACT_LOOKUP && req.action != lbcd_pkg::ACT_FILL)
        other_words++;
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp_q.size() == 0) begin
        $error("result word arrived with no request outstanding");
        fail_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (want.hit) hit_count++;
        if (want.evicted_valid) evict_count++;
        check_field("hit", want.hit, rsp.hit);
        check_field("slot", want.slot, rsp.slot);
        check_field("evicted_valid", want.evicted_valid, rsp.evicted_valid);
        check_field("evicted_block", want.evicted_block, rsp.evicted_block);
        check_field("sequential", want.sequential, rsp.sequential);
        check_field("request_total", want.request_total, rsp.request_total);
        check_field("sequential_total", want.sequential_total, rsp.sequential_total);
        check_field("random_total", want.random_total, rsp.random_total);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: present the head of the pending queue at the falling edge.
  // Hold a word until it is taken; idle in bursts; wait for the result queue to
  // drain before any word marked for it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_fire) begin
      // hold: the offered word has not been taken yet
    end else if (send_gap > 0) begin
      send_gap--;
      req_valid <= 1'b0;
    end else if (pending_q.size() == 0 ||
                 (pending_q[0].drain_first && expected_rsp_q.size() != 0)) begin
      req_valid <= 1'b0;
    end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
      send_gap = $urandom_range(1, 16) - 1;
      req_valid <= 1'b0;
    end else begin
      req       <= pending_q[0].word;
      req_valid <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall in random bursts, and once hold off for a long
  // stretch so both registers fill and the request side backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!long_hold_done && words_taken >= 300) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      rsp_stall     <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (idle_allowed() && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random traffic built from fill runs,
  // mixed lookups and fills over a working set, and occasional noise.
  // ---------------------------------------------------------------------------
  initial begin
    logic [lbcd_pkg::BLOCK_W-1:0] base;
    logic [lbcd_pkg::BLOCK_W-1:0] id;
    int                           kind;
    int                           n;
    int                           pick;
    bit                           drain;

    empty_directory();
    lookups_seen    = '0;
    seq_fills_seen  = '0;
    rand_fills_seen = '0;

    queue_word(lbcd_pkg::ACT_LOOKUP, 32'h0, 1'b0);          // miss on an empty cache
    queue_word(lbcd_pkg::ACT_FILL, 32'h0, 1'b0);            // first fill, never sequential
    queue_word(lbcd_pkg::ACT_FILL, 32'h1, 1'b0);            // neighbor of the last fill
    queue_word(lbcd_pkg::ACT_FILL, 32'hFFFF_FFFF, 1'b0);    // no wrap: 1 and max are far apart
    queue_word(lbcd_pkg::ACT_FILL, 32'hFFFF_FFFE, 1'b0);
    queue_word(lbcd_pkg::ACT_FILL, 32'hFFFF_FFFF, 1'b0);    // fill of a block already held
    queue_word(lbcd_pkg::ACT_LOOKUP, 32'h1, 1'b0);          // hit
    queue_word(lbcd_pkg::ACT_LOOKUP, 32'h2, 1'b0);          // miss on a partly filled cache
    queue_word(ACT_UNUSED, 32'hFFFF_FFFF, 1'b0);            // ignored code
    queue_word(lbcd_pkg::ACT_FILL, 32'hAAAA_AAAA, 1'b0);
    queue_word(lbcd_pkg::ACT_FILL, 32'h5555_5555, 1'b0);
    for (int i = 0; i < 10; i++)
      queue_word(lbcd_pkg::ACT_FILL, 32'h0001_0000 + 32'(i) * 32'h10, 1'b0);
    queue_word(lbcd_pkg::ACT_FILL, 32'h1234_5678, 1'b0);    // full cache: evict block zero
    queue_word(lbcd_pkg::ACT_FLUSH, 32'hFFFF_FFFF, 1'b0);
    queue_word(lbcd_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0);  // miss after flush
    queue_word(lbcd_pkg::ACT_FILL, 32'h1234_5679, 1'b0);    // first fill after flush

    base = $urandom;
    while (pending_q.size() < DIRECTED_WORDS + RANDOM_WORDS) begin
      kind  = $urandom_range(0, 9);
      drain = (pending_q.size() == DIRECTED_WORDS) || ($urandom_range(0, 11) == 0);
      if (kind <= 1) begin
        // move the working set, sometimes against either end of the id range
        case ($urandom_range(0, 2))
          0:       base = $urandom;
          1:       base = $urandom_range(0, 6);
          default: base = 32'hFFFF_FFFF - $urandom_range(0, 20);
        endcase
      end
      if (kind <= 4) begin
        // streaming run of neighboring fills, then read a few back
        n  = $urandom_range(3, 14);
        id = base + $urandom_range(0, 23);
        for (int i = 0; i < n; i++) begin
          queue_word(lbcd_pkg::ACT_FILL, id, drain && i == 0);
          case ($urandom_range(0, 5))
            0:       id = id - 1;
            1:       id = id + 2;
            default: id = id + 1;
          endcase
        end
        repeat ($urandom_range(1, 6))
          queue_word(lbcd_pkg::ACT_LOOKUP, base + $urandom_range(0, 23), 1'b0);
      end else if (kind <= 8) begin
        // mixed traffic over a working set somewhat larger than the cache
        repeat ($urandom_range(4, 16)) begin
          pick = $urandom_range(0, 9);
          id   = (pick == 0) ? $urandom : base + $urandom_range(0, 23);
          queue_word((pick < 5) ? lbcd_pkg::ACT_LOOKUP : lbcd_pkg::ACT_FILL, id, drain);
          drain = 1'b0;
        end
      end else begin
        // noise: flush everything, or the unused code
        queue_word($urandom_range(0, 1) ? lbcd_pkg::ACT_FLUSH : ACT_UNUSED, $urandom, drain);
      end
    end
    word_total = pending_q.size();

    repeat (5) @(negedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // End of run: wait until every word is taken and every result has come back,
  // allow a few more edges for stray results, then report.
  // ---------------------------------------------------------------------------
  initial begin
    @(negedge rst);
    while (pending_q.size() != 0 || expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d request words: %0d lookups, %0d fills (%0d sequential)",
             words_taken, lookups_seen, seq_fills_seen + rand_fills_seen, seq_fills_seen);
    $display("Also %0d flush/unused; %0d hits, %0d evictions; request side backed up %0d cycles",
             other_words, hit_count, evict_count, backpressure_cycles);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d words taken", cycle_count, words_taken);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lbcd_pkg.sv
hw/rtl/lbcd_dir.sv
hw/rtl/lbcd_stats.sv
hw/rtl/lru_block_cache_directory.sv
tb/sv/lru_block_cache_directory_test.sv
